FILE: rtl/pcw_pkg.sv
package pcw_pkg;

	localparam int WINDOW_ENTRIES = 8;
	localparam int IDX_W = (WINDOW_ENTRIES > 1) ? $clog2(WINDOW_ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW_ENTRIES - 1);

	localparam logic REQ_LOOKUP = 1'b0;
	localparam logic REQ_REMEMBER = 1'b1;

	typedef struct packed {
		logic        req_type;
		logic [31:0] sequence_req;
		logic [7:0]  packet_type;
		logic [7:0]  ack_code;
	} req_word_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] found_result;
	} rsp_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRITE,
		ST_SCAN,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic latch;
		logic write;
		logic scan_clear;
		logic scan_step;
		logic load_out;
	} dp_cmd_t;

	typedef struct packed {
		logic remember;
		logic match;
		logic scan_last;
		logic out_free;
	} dp_status_t;

endpackage

FILE: rtl/processed_command_window_core.sv
// Duplicate-command window with a fixed number of entries.
// The req channel (req_valid, req_stall, req) takes one word per command.
// A remember word stores sequence, packet type and result at the write
// cursor, which wraps so that the oldest entry is replaced first.
// A lookup word compares the entries one per cycle from index zero and
// reports the first valid match with its stored result, or a miss.
// Every request word yields exactly one word on the rsp channel
// (rsp_valid, rsp_stall, rsp); a remember word yields hit = 0, result 0.
// A remember passes through the scan, write and emit states; a lookup stays
// in the scan state until the single entry comparator finds a match or
// reaches the last entry, then emits. req_stall is high from acceptance
// until the response is loaded into the output register, so the next
// word is taken while a response still waits there.
// When rsp_stall is high the response holds; a finished request then waits
// for the output register to free up.
// arst_n clears every valid mark, the write cursor and the output valid flag.
module processed_command_window_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  pcw_pkg::req_word_t req,
	output logic               rsp_valid,
	input  logic               rsp_stall,
	output pcw_pkg::rsp_word_t rsp
);
	import pcw_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	pcw_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.status    (status),
		.cmd       (cmd)
	);

	pcw_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

FILE: rtl/pcw_ctrl.sv
module pcw_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_stall,
	input  pcw_pkg::dp_status_t status,
	output pcw_pkg::dp_cmd_t   cmd
);
	import pcw_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (status.remember) begin
					state_d = ST_WRITE;
				end else if (status.match || status.scan_last) begin
					state_d = ST_EMIT;
				end
			end
			ST_WRITE: begin
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (status.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd = '0;
		req_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				req_stall = 1'b0;
				cmd.latch = req_valid;
				cmd.scan_clear = req_valid;
			end
			ST_SCAN: begin
				cmd.scan_step = !status.remember;
			end
			ST_WRITE: begin
				cmd.write = 1'b1;
			end
			ST_EMIT: begin
				cmd.load_out = status.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

FILE: rtl/pcw_datapath.sv
module pcw_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  pcw_pkg::req_word_t  req,
	input  pcw_pkg::dp_cmd_t    cmd,
	output pcw_pkg::dp_status_t status,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output pcw_pkg::rsp_word_t  rsp
);
	import pcw_pkg::*;

	req_word_t                 req_q;
	logic [WINDOW_ENTRIES-1:0] slot_valid_q;
	logic [31:0]               slot_sequence_q [WINDOW_ENTRIES];
	logic [7:0]                slot_type_q [WINDOW_ENTRIES];
	logic [7:0]                slot_result_q [WINDOW_ENTRIES];
	logic [IDX_W-1:0]          cursor_q;
	logic [IDX_W-1:0]          scan_idx_q;
	logic                      found_hit_q;
	logic [7:0]                found_res_q;
	logic                      out_valid_q;
	rsp_word_t                 out_word_q;
	logic                      match;

	assign match = slot_valid_q[scan_idx_q]
		&& (slot_sequence_q[scan_idx_q] == req_q.sequence_req)
		&& (slot_type_q[scan_idx_q] == req_q.packet_type);

	assign status.remember = (req_q.req_type == REQ_REMEMBER);
	assign status.match = match;
	assign status.scan_last = (scan_idx_q == LAST_IDX);
	assign status.out_free = !out_valid_q || !rsp_stall;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			req_q <= req;
		end
		if (cmd.write) begin
			slot_sequence_q[cursor_q] <= req_q.sequence_req;
			slot_type_q[cursor_q] <= req_q.packet_type;
			slot_result_q[cursor_q] <= req_q.ack_code;
		end
		if (cmd.scan_clear) begin
			scan_idx_q <= '0;
			found_hit_q <= 1'b0;
			found_res_q <= '0;
		end else if (cmd.scan_step) begin
			if (match) begin
				found_hit_q <= 1'b1;
				found_res_q <= slot_result_q[scan_idx_q];
			end else if (scan_idx_q != LAST_IDX) begin
				scan_idx_q <= scan_idx_q + 1'b1;
			end
		end
		if (cmd.load_out) begin
			out_word_q.hit <= found_hit_q;
			out_word_q.found_result <= found_res_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q <= '0;
			cursor_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.write) begin
				slot_valid_q[cursor_q] <= 1'b1;
				cursor_q <= (cursor_q == LAST_IDX) ? '0 : cursor_q + 1'b1;
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_word_q;

endmodule

FILE: rtl/pcw_checker.sv
module pcw_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_stall,
	input logic               rsp_valid,
	input logic               rsp_stall,
	input pcw_pkg::rsp_word_t rsp
);
	import pcw_pkg::*;

	a_rsp_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid)
		else $error("rsp_valid dropped while stalled");

	a_rsp_stable: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> $stable(rsp))
		else $error("rsp word changed while stalled");

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp.hit |-> rsp.found_result == 8'd0)
		else $error("miss word carries a nonzero result");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken again right after acceptance");

endmodule

bind processed_command_window_core pcw_checker u_pcw_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;
	import pcw_pkg::*;

	localparam int QUIET_LIMIT = 4000;
	localparam int RANDOM_WORDS = 2000;
	localparam int POOL_SIZE = 12;

	typedef struct packed {
		req_word_t w;
		logic      pinned;
		rsp_word_t r;
	} stim_row_t;

	typedef struct packed {
		logic      pinned;
		rsp_word_t r;
	} pin_note_t;

	logic      clk;
	logic      arst_n;
	logic      req_valid;
	logic      req_stall;
	req_word_t req;
	logic      rsp_valid;
	logic      rsp_stall;
	rsp_word_t rsp;

	logic        win_valid [WINDOW_ENTRIES];
	logic [31:0] win_seq [WINDOW_ENTRIES];
	logic [7:0]  win_type [WINDOW_ENTRIES];
	logic [7:0]  win_result [WINDOW_ENTRIES];
	int          win_cursor;

	rsp_word_t rsp_due_q [$];
	pin_note_t pinned_q [$];
	stim_row_t directed_rows [$];

	logic [31:0] pool_seq [POOL_SIZE];
	logic [7:0]  pool_type [POOL_SIZE];

	int errors;
	int quiet_cycles;
	int send_idle_pct;
	int stall_pct;

	rsp_word_t predicted;
	rsp_word_t due;
	pin_note_t note;

	processed_command_window_core u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic rsp_word_t apply_to_window(input req_word_t w);
		rsp_word_t r;
		r = '0;
		if (w.req_type == REQ_REMEMBER) begin
			win_valid[win_cursor] = 1'b1;
			win_seq[win_cursor] = w.sequence_req;
			win_type[win_cursor] = w.packet_type;
			win_result[win_cursor] = w.ack_code;
			win_cursor = (win_cursor + 1) % WINDOW_ENTRIES;
		end else begin
			for (int i = 0; i < WINDOW_ENTRIES; i++) begin
				if (win_valid[i] && win_seq[i] == w.sequence_req &&
						win_type[i] == w.packet_type) begin
					r.hit = 1'b1;
					r.found_result = win_result[i];
					break;
				end
			end
		end
		return r;
	endfunction

	function automatic stim_row_t mk_row(input logic op, input logic [31:0] s,
			input logic [7:0] t, input logic [7:0] a, input logic pin,
			input logic h, input logic [7:0] fr);
		stim_row_t row;
		row.w.req_type = op;
		row.w.sequence_req = s;
		row.w.packet_type = t;
		row.w.ack_code = a;
		row.pinned = pin;
		row.r.hit = h;
		row.r.found_result = fr;
		return row;
	endfunction

	function automatic req_word_t random_command();
		req_word_t w;
		int k;
		int pick;
		k = $urandom_range(POOL_SIZE - 1);
		pick = $urandom_range(99);
		w.ack_code = 8'($urandom);
		w.req_type = ($urandom_range(99) < 45) ? REQ_REMEMBER : REQ_LOOKUP;
		w.sequence_req = pool_seq[k];
		w.packet_type = pool_type[k];
		if (pick >= 85) begin
			w.sequence_req = $urandom;
			w.packet_type = 8'($urandom);
		end else if (pick >= 78) begin
			w.sequence_req = pool_seq[k] ^ (32'h1 << $urandom_range(31));
		end else if (pick >= 70) begin
			w.packet_type = pool_type[k] ^ (8'h1 << $urandom_range(7));
		end
		return w;
	endfunction

	task automatic report_mismatch(input string msg);
		errors++;
		if (errors <= 100)
			$display("mismatch at %0t: %s", $realtime, msg);
	endtask

	task automatic send_word(input req_word_t w, input logic pin, input rsp_word_t r);
		pinned_q.push_back('{pinned: pin, r: r});
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req <= w;
		req_valid <= 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic drain_window();
		req_valid <= 1'b0;
		while (rsp_due_q.size() != 0 || pinned_q.size() != 0)
			@(negedge clk);
	endtask

	always @(negedge clk) begin
		rsp_stall <= arst_n && ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n) begin
			quiet_cycles <= ((rsp_valid && !rsp_stall) || (req_valid && !req_stall)) ?
				0 : quiet_cycles + 1;
			if (rsp_valid && !rsp_stall) begin
				if (rsp_due_q.size() == 0) begin
					report_mismatch($sformatf("unexpected word hit=%0b result=%02h",
						rsp.hit, rsp.found_result));
				end else begin
					due = rsp_due_q.pop_front();
					if (rsp.hit !== due.hit)
						report_mismatch($sformatf("hit %0b, expected %0b",
							rsp.hit, due.hit));
					if (rsp.found_result !== due.found_result)
						report_mismatch($sformatf("found_result %02h, expected %02h",
							rsp.found_result, due.found_result));
				end
			end
			if (req_valid && !req_stall) begin
				predicted = apply_to_window(req);
				note = pinned_q.pop_front();
				rsp_due_q.push_back(note.pinned ? note.r : predicted);
			end
		end
	end

	initial begin
		do @(posedge clk); while (quiet_cycles < QUIET_LIMIT);
		$display("tb: done, errors");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		req_valid = 1'b0;
		req = '0;
		rsp_stall = 1'b0;
		errors = 0;
		quiet_cycles = 0;
		send_idle_pct = 7;
		stall_pct = 74;
		win_cursor = 0;
		for (int i = 0; i < WINDOW_ENTRIES; i++) begin
			win_valid[i] = 1'b0;
			win_seq[i] = '0;
			win_type[i] = '0;
			win_result[i] = '0;
		end

		directed_rows = '{
			mk_row(REQ_LOOKUP,   32'h00000000, 8'h00, 8'hFF, 1'b1, 1'b0, 8'h00),
			mk_row(REQ_LOOKUP,   32'hFFFFFFFF, 8'hFF, 8'h00, 1'b1, 1'b0, 8'h00),
			mk_row(REQ_REMEMBER, 32'h00000000, 8'h00, 8'hFF, 1'b1, 1'b0, 8'h00),
			mk_row(REQ_LOOKUP,   32'h00000000, 8'h00, 8'h00, 1'b1, 1'b1, 8'hFF),
			mk_row(REQ_REMEMBER, 32'hFFFFFFFF, 8'hFF, 8'h00, 1'b1, 1'b0, 8'h00),
			mk_row(REQ_LOOKUP,   32'hFFFFFFFF, 8'hFF, 8'h5A, 1'b1, 1'b1, 8'h00),
			mk_row(REQ_LOOKUP,   32'hFFFFFFFF, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00),
			mk_row(REQ_LOOKUP,   32'h00000000, 8'hFF, 8'h00, 1'b0, 1'b0, 8'h00),
			mk_row(REQ_REMEMBER, 32'h12345678, 8'h5A, 8'h11, 1'b1, 1'b0, 8'h00),
			mk_row(REQ_REMEMBER, 32'h12345678, 8'h5A, 8'h22, 1'b1, 1'b0, 8'h00),
			mk_row(REQ_LOOKUP,   32'h12345678, 8'h5A, 8'h00, 1'b0, 1'b0, 8'h00),
			mk_row(REQ_REMEMBER, 32'h80000000, 8'h80, 8'h01, 1'b1, 1'b0, 8'h00),
			mk_row(REQ_REMEMBER, 32'h00000001, 8'h01, 8'h80, 1'b1, 1'b0, 8'h00),
			mk_row(REQ_REMEMBER, 32'h7FFFFFFF, 8'h7F, 8'hFE, 1'b1, 1'b0, 8'h00),
			mk_row(REQ_REMEMBER, 32'h12345678, 8'h5A, 8'h33, 1'b1, 1'b0, 8'h00),
			mk_row(REQ_LOOKUP,   32'h12345678, 8'h5A, 8'hA5, 1'b0, 1'b0, 8'h00),
			mk_row(REQ_REMEMBER, 32'h12345678, 8'h5A, 8'h44, 1'b1, 1'b0, 8'h00),
			mk_row(REQ_LOOKUP,   32'h12345678, 8'h5A, 8'h00, 1'b0, 1'b0, 8'h00),
			mk_row(REQ_LOOKUP,   32'h00000000, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00),
			mk_row(REQ_REMEMBER, 32'h12345678, 8'h5A, 8'h55, 1'b1, 1'b0, 8'h00),
			mk_row(REQ_LOOKUP,   32'h80000000, 8'h80, 8'h00, 1'b0, 1'b0, 8'h00),
			mk_row(REQ_LOOKUP,   32'h12345679, 8'h5A, 8'h00, 1'b0, 1'b0, 8'h00),
			mk_row(REQ_LOOKUP,   32'h00000001, 8'h01, 8'h00, 1'b0, 1'b0, 8'h00)
		};

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			send_word(directed_rows[i].w, directed_rows[i].pinned, directed_rows[i].r);

		for (int phase = 0; phase < 3; phase++) begin
			// Each phase draws a fresh pool so that repeated words hit and evict.
			drain_window();
			send_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 74 : 0;
			stall_pct = (phase == 0) ? 74 : (phase == 1) ? 7 : 0;
			for (int k = 0; k < POOL_SIZE; k++) begin
				pool_seq[k] = $urandom;
				pool_type[k] = 8'($urandom);
			end
			for (int n = 0; n < RANDOM_WORDS / 3; n++)
				send_word(random_command(), 1'b0, '0);
		end

		drain_window();
		repeat (WINDOW_ENTRIES + 8) @(negedge clk);
		if (errors == 0) begin
			$display("tb: done, clean");
		end else begin
			$display("tb: done, errors");
		end
		$finish;
	end

endmodule
